// ===== sv/vst_pkg.sv =====
// Package with shared types, constants and a helper function of the vibration statistics tracker.
package vst_pkg;

   localparam int unsigned AxisCount = 3;
   localparam logic [15:0] SensFallback = 16'd3998;
   localparam logic [23:0] LevelFloor = 24'd256;
   localparam logic [23:0] Max24 = 24'hFFFFFF;
   localparam logic [62:0] Max63 = {63{1'b1}};
   localparam logic [1:0] TopScale = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] RegBaseSens = 2'd0;
   localparam logic [1:0] RegClip = 2'd1;
   localparam logic [1:0] RegDcAlpha = 2'd2;
   localparam logic [1:0] RegLevelBeta = 2'd3;

   localparam logic [15:0] ResetBaseSens = 16'd3998;
   localparam logic [14:0] ResetClip = 15'd30000;
   localparam logic [15:0] ResetDcAlpha = 16'd655;
   localparam logic [15:0] ResetLevelBeta = 16'd655;

   // A scaled axis stays below 2^27, so the sum of three squares fits in 58 bits.
   localparam int unsigned AxisScaledWidth = 28;
   localparam int unsigned SumWidth = 58;
   localparam int unsigned RootWidth = SumWidth / 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ROOT,
      ST_STATS,
      ST_LEVEL,
      ST_OUT
   } state_type;

   function automatic logic [15:0] axis_abs(input logic [15:0] raw);
      logic [16:0] mag;
      begin
         mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
         axis_abs = mag[15:0];
      end
   endfunction

endpackage

// ===== sv/vst_lane.sv =====
// One axis lane: scaling of the axis magnitude to Q.8 mg, then squaring; both results are registered.
module vst_lane
   import vst_pkg::*;
(
   input  logic                         clock,
   input  logic                         load,
   input  logic [16:0]                  axis_mag,
   input  logic [18:0]                  sens,
   output logic [2*AxisScaledWidth-1:0] square
);
   logic [AxisScaledWidth-1:0]   scaled_ff;
   logic [AxisScaledWidth-1:0]   scaled_in;
   logic [2*AxisScaledWidth-1:0] square_ff;
   logic [35:0]                  product;

   assign product   = axis_mag * sens;
   assign scaled_in = AxisScaledWidth'((product + 36'd128) >> 8);

   always_ff @(posedge clock) begin
      if (load) begin
         scaled_ff <= scaled_in;
      end
      square_ff <= scaled_ff * scaled_ff;
   end

   assign square = square_ff;
endmodule

// ===== sv/vst_isqrt.sv =====
// Bit-pair iterative integer square root, one result bit per cycle.
module vst_isqrt
   import vst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SumWidth-1:0]  radicand,
   output logic                 done,
   output logic [RootWidth-1:0] root
);
   localparam int unsigned CountWidth = $clog2(RootWidth + 1);

   logic [RootWidth-1:0]  root_ff;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic [RootWidth+1:0]  trial;

   assign trial  = {root_ff, 2'b01};

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         count_in = CountWidth'(RootWidth);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         count_in = count_ff - 1'b1;
         if (count_ff == CountWidth'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Datapath: separate shifting radicand and partial remainder.
   logic [SumWidth-1:0]  src_ff;
   logic [RootWidth+1:0] part_ff;
   logic [RootWidth+1:0] part_shift;
   logic [RootWidth+1:0] part_next;
   logic                 fits;

   assign part_shift = {part_ff[RootWidth-1:0], src_ff[SumWidth-1 -: 2]};
   assign fits       = part_shift >= trial;
   assign part_next  = fits ? (part_shift - trial) : part_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      if (start) begin
         src_ff  <= radicand;
         part_ff <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         src_ff  <= {src_ff[SumWidth-3:0], 2'b00};
         part_ff <= part_next;
         root_ff <= {root_ff[RootWidth-2:0], fits};
      end
   end

   assign done = busy_ff && (count_ff == CountWidth'(1));
   assign root = {root_ff[RootWidth-2:0], fits};
endmodule

// ===== sv/vibration_statistics_tracker.sv =====
// Top level of the vibration statistics tracker: control, lanes, root and statistics merge.
// Each accepted sample passes through scaling, the bit-serial square root and the statistics
// update in turn; a new request is taken only once the last result is in the output register.
// A new request is taken while an earlier response still waits, up to one held response.
// Reset is synchronous and active high; it restores the register defaults and clears all
// statistics, the range code and the first-sample flags.
module vibration_statistics_tracker
   import vst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // accel_x, accel_y, accel_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // dc_level, peak_deviation, median_level, jerk_peak,
                                     // jerk_square_sum, sample_total
   output logic [2:0]   rsp_tuser,   // full_scale_code, scale_changed
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);
   logic [15:0] base_sens_ff;
   logic [14:0] clip_ff;
   logic [15:0] dc_alpha_ff;
   logic [15:0] level_beta_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_sens_ff  <= ResetBaseSens;
         clip_ff       <= ResetClip;
         dc_alpha_ff   <= ResetDcAlpha;
         level_beta_ff <= ResetLevelBeta;
      end else if (csr_valid) begin
         case (csr_index)
            RegBaseSens:  base_sens_ff  <= csr_data;
            RegClip:      clip_ff       <= csr_data[14:0];
            RegDcAlpha:   dc_alpha_ff   <= csr_data;
            RegLevelBeta: level_beta_ff <= csr_data;
            default:      base_sens_ff  <= base_sens_ff;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       accept, root_start, root_done;

   // Statistics state.
   logic [1:0]  scale_ff, scale_in;
   logic        changed_ff, changed_in;
   logic [23:0] dc_ff, peak_dev_ff, level_ff, prev_mag_ff, jerk_max_ff, mag_ff, dev_ff;
   logic [62:0] jerk_acc_ff;
   logic [31:0] count_ff;
   logic        dc_started_ff, level_started_ff, prev_valid_ff;
   logic [16:0] axis_ff [AxisCount];
   logic [2*AxisScaledWidth-1:0] square [AxisCount];
   logic [RootWidth-1:0] root;
   logic [SumWidth-1:0]  sum;

   // Output holding register.
   logic          out_valid_ff;
   logic [191:0]  out_data_ff;
   logic [2:0]    out_user_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   logic [15:0] abs_in [AxisCount];
   logic [15:0] mmax;
   always_comb begin
      for (int i = 0; i < AxisCount; i++) begin
         abs_in[i] = axis_abs(req_tdata[16*i +: 16]);
      end
      mmax = abs_in[0];
      if (abs_in[1] > mmax) mmax = abs_in[1];
      if (abs_in[2] > mmax) mmax = abs_in[2];
   end

   always_comb begin
      scale_in   = scale_ff;
      changed_in = changed_ff;
      if (accept) begin
         changed_in = 1'b0;
         if ((mmax > {1'b0, clip_ff}) && (scale_ff != TopScale)) begin
            scale_in   = scale_ff + 1'b1;
            changed_in = 1'b1;
         end
      end
   end

   logic [18:0] sens;
   assign sens = {3'b000, (base_sens_ff != 16'd0) ? base_sens_ff : SensFallback} << scale_ff;

   genvar g;
   generate
      for (g = 0; g < AxisCount; g++) begin : g_lane
         vst_lane u_lane (
            .clock    (clock),
            .load     (state_ff == ST_SCALE && phase_ff == 2'd0),
            .axis_mag (axis_ff[g]),
            .sens     (sens),
            .square   (square[g])
         );
      end
   endgenerate

   // Merge of the three lanes' squares.
   assign sum = SumWidth'(square[0]) + SumWidth'(square[1]) + SumWidth'(square[2]);
   assign root_start = (state_ff == ST_SCALE) && (phase_ff == 2'd2);

   vst_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum),
      .done     (root_done),
      .root     (root)
   );

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCALE;
               phase_in = 2'd0;
            end
         end
         ST_SCALE: begin
            phase_in = phase_ff + 1'b1;
            if (phase_ff == 2'd2) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_STATS;
               phase_in = 2'd0;
            end
         end
         ST_STATS: begin
            phase_in = phase_ff + 1'b1;
            if (phase_ff == 2'd1) begin
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Statistics arithmetic, spread over the stats phases.
   logic [23:0] mag_sat, dc_base, dev_calc, dc_step, level_b, jerk;
   logic [39:0] dc_prod, level_prod;
   logic [24:0] level_up;
   logic [23:0] level_next;
   logic [47:0] jerk_sq;
   logic [63:0] jerk_sum;

   assign mag_sat  = (root > RootWidth'(Max24)) ? Max24 : root[23:0];
   assign dc_base  = dc_started_ff ? dc_ff : mag_ff;
   assign dev_calc = (mag_ff > dc_base) ? (mag_ff - dc_base) : (dc_base - mag_ff);
   assign dc_prod  = dev_ff * dc_alpha_ff;
   assign dc_step  = dc_prod[39:16];
   assign level_prod = level_ff * level_beta_ff;
   assign level_b  = level_prod[39:16];
   assign level_up = {1'b0, level_ff} + {1'b0, level_b};
   assign jerk     = (mag_ff > prev_mag_ff) ? (mag_ff - prev_mag_ff) : (prev_mag_ff - mag_ff);
   assign jerk_sq  = jerk * jerk;
   assign jerk_sum = {1'b0, jerk_acc_ff} + {16'd0, jerk_sq};

   always_comb begin
      if (!level_started_ff) begin
         level_next = (dev_ff > LevelFloor) ? dev_ff : LevelFloor;
      end else if (dev_ff > level_ff) begin
         level_next = level_up[24] ? Max24 : level_up[23:0];
      end else begin
         level_next = (level_b > level_ff) ? 24'd0 : (level_ff - level_b);
      end
      if (level_next < LevelFloor) level_next = LevelFloor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         phase_ff         <= '0;
         scale_ff         <= '0;
         changed_ff       <= 1'b0;
         dc_ff            <= '0;
         dc_started_ff    <= 1'b0;
         peak_dev_ff      <= '0;
         level_ff         <= '0;
         level_started_ff <= 1'b0;
         prev_mag_ff      <= '0;
         prev_valid_ff    <= 1'b0;
         jerk_max_ff      <= '0;
         jerk_acc_ff      <= '0;
         count_ff         <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         scale_ff   <= scale_in;
         changed_ff <= changed_in;
         if (state_ff == ST_STATS && phase_ff == 2'd0) begin
            dev_ff <= dev_calc;
            dc_ff  <= dc_base;
            dc_started_ff <= 1'b1;
            if (dev_calc > peak_dev_ff) peak_dev_ff <= dev_calc;
            if (count_ff != 32'hFFFFFFFF) count_ff <= count_ff + 1'b1;
            if (prev_valid_ff) begin
               if (jerk > jerk_max_ff) jerk_max_ff <= jerk;
               jerk_acc_ff <= (jerk_sum > {1'b0, Max63}) ? Max63 : jerk_sum[62:0];
            end
            prev_valid_ff <= 1'b1;
            prev_mag_ff   <= mag_ff;
         end
         if (state_ff == ST_STATS && phase_ff == 2'd1) begin
            dc_ff <= (mag_ff > dc_ff) ? (dc_ff + dc_step) : (dc_ff - dc_step);
            level_ff <= level_next;
            level_started_ff <= 1'b1;
         end
         if (state_ff == ST_OUT && (!out_valid_ff || rsp_tready)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         for (int i = 0; i < AxisCount; i++) begin
            axis_ff[i] <= {1'b0, abs_in[i]};
         end
      end
      if (root_done) begin
         mag_ff <= mag_sat;
      end
      if (state_ff == ST_OUT && (!out_valid_ff || rsp_tready)) begin
         out_data_ff <= {1'b0, count_ff, jerk_acc_ff, jerk_max_ff, level_ff, peak_dev_ff, dc_ff};
         out_user_ff <= {changed_ff, scale_ff};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   a_level_floor: assert property (@(posedge clock) disable iff (reset)
      level_started_ff |-> (level_ff >= LevelFloor)) else $error("median below floor");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCALE)) else $error("accept did not start work");
   a_root_in_root: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == ST_ROOT)) else $error("root done outside root phase");
endmodule
